@@ hdl/ist_pkg.sv @@
// ist_pkg: opcode constants and result type for the integer set table
// no dependencies; imported by integer_set_table_core
package ist_pkg;

  // operation codes; the unused code behaves as a query
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;

  // one result beat
  typedef struct packed {
    logic              found;
    logic              changed;
    logic              full_res;
    logic [CountW-1:0] count;
  } ist_res_t;

endpackage

@@ hdl/integer_set_table_core.sv @@
// integer_set_table_core: unordered set of 32-bit values in one synchronous memory
// depends on ist_pkg (opcodes, result type)
// an empty set is answered from idle with no scan; otherwise entries are scanned in order until a hit or the end,
// and an erase then moves each later entry down one place before its result beat;
// busy_o drops in the cycle the result beat is shown, so a new item may start then.
// the single read port (one entry per cycle) sets the rate; results cannot be stalled.
// reset clears the count and control only; memory contents need no clearing.
module integer_set_table_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   opcode_i,
  input  logic signed [ist_pkg::ValueW-1:0] value_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic                         changed_o,
  output logic                         full_res_o,
  output logic [ist_pkg::CountW-1:0]   count_o
);
  import ist_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [1:0]          op_q, op_d;
  logic [ValueW-1:0]   val_q, val_d;
  ist_res_t            res_q, res_d;
  logic                done_q, done_d;

  // entry memory, one read and one write port
  logic [ValueW-1:0]   mem_q [CAPACITY];
  logic [ValueW-1:0]   rdata_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ValueW-1:0]   wr_data;

  logic [CW-1:0]       idx_nxt;
  logic                more;
  logic                hit;
  logic [CW+CountW-1:0] cnt_ext;

  assign idx_nxt = CW'(idx_q) + CW'(1);
  assign more    = idx_nxt < cnt_q;
  assign hit     = rdata_q == val_q;

  // result fields for a finishing item, count given as the next count
  function automatic ist_res_t make_res(logic f, logic c, logic fl, logic [CW-1:0] n);
    logic [CW+CountW-1:0] ext;
    ist_res_t r;
    ext        = {{CountW{1'b0}}, n};
    r.found    = f;
    r.changed  = c;
    r.full_res = fl;
    r.count    = ext[CountW-1:0];
    return r;
  endfunction

  // sequencer: scan, then append on add, compact on erase, or only report
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    op_d    = op_q;
    val_d   = val_q;
    res_d   = res_q;
    done_d  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d  = opcode_i;
          val_d = value_i;
          idx_d = '0;
          if (cnt_q == '0) begin
            // empty set: answer at once
            if (opcode_i == OP_ADD) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = value_i;
              cnt_d   = CW'(1);
              res_d   = make_res(1'b0, 1'b1, 1'b0, CW'(1));
            end else begin
              res_d = make_res(1'b0, 1'b0, 1'b0, cnt_q);
            end
            done_d = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          if (op_q == OP_ERASE) begin
            if (more) begin
              // start moving later entries down
              rd_en   = 1'b1;
              rd_addr = idx_nxt[AW-1:0];
              idx_d   = idx_nxt[AW-1:0];
              state_d = ST_SHIFT;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              res_d   = make_res(1'b1, 1'b1, 1'b0, cnt_q - CW'(1));
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            res_d   = make_res(1'b1, 1'b0, 1'b0, cnt_q);
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = idx_nxt[AW-1:0];
          idx_d   = idx_nxt[AW-1:0];
        end else begin
          // value absent
          if (op_q == OP_ADD) begin
            if (cnt_q < CW'(CAPACITY)) begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[AW-1:0];
              wr_data = val_q;
              cnt_d   = cnt_q + CW'(1);
              res_d   = make_res(1'b0, 1'b1, 1'b0, cnt_q + CW'(1));
            end else begin
              res_d = make_res(1'b0, 1'b0, 1'b1, cnt_q);
            end
          end else begin
            res_d = make_res(1'b0, 1'b0, 1'b0, cnt_q);
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        // read runs one entry ahead of the write
        wr_en   = 1'b1;
        wr_addr = idx_q - AW'(1);
        wr_data = rdata_q;
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = idx_nxt[AW-1:0];
          idx_d   = idx_nxt[AW-1:0];
        end else begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = make_res(1'b1, 1'b1, 1'b0, cnt_q - CW'(1));
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    op_q  <= op_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign cnt_ext    = {{CountW{1'b0}}, cnt_q};
  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign found_o    = res_q.found;
  assign changed_o  = res_q.changed;
  assign full_res_o = res_q.full_res;
  assign count_o    = done_q ? res_q.count : cnt_ext[CountW-1:0];

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// testbench for integer_set_table_core: add, erase and query beats checked against a predictor
// depends on ist_pkg (opcodes, ValueW, CountW, ist_res_t) and integer_set_table_core
module testbench;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned PoolSize = 160;
  // the fourth opcode has no name in the package; it acts as a query
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic signed [ist_pkg::ValueW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ist_pkg::ValueW-1:0] ValMax = 32'sh7FFF_FFFF;

  logic                               clk_i    = 1'b0;
  logic                               rst_ni   = 1'b0;
  logic                               start_i  = 1'b0;
  logic [1:0]                         opcode_i = ist_pkg::OP_QUERY;
  logic signed [ist_pkg::ValueW-1:0]  value_i  = '0;
  logic                               busy_o;
  logic                               done_o;
  logic                               found_o;
  logic                               changed_o;
  logic                               full_res_o;
  logic [ist_pkg::CountW-1:0]         count_o;

  // predicted contents of the set, compacted at the bottom
  logic signed [ist_pkg::ValueW-1:0]  held_vals [CAPACITY];
  int unsigned                        held_n = 0;
  ist_pkg::ist_res_t                  predicted_res_q [$];

  bit          idle_en = 1'b1;
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned refused_adds = 0;
  int unsigned peak_count = 0;

  integer_set_table_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .opcode_i  (opcode_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .found_o   (found_o),
    .changed_o (changed_o),
    .full_res_o(full_res_o),
    .count_o   (count_o)
  );

  // clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // set behavior: linear search, append on add, shift down on erase
  function automatic ist_pkg::ist_res_t apply_set_op(input logic [1:0] op,
                                                      input logic signed [ist_pkg::ValueW-1:0] v);
    ist_pkg::ist_res_t r;
    int pos;
    pos = -1;
    for (int i = 0; i < held_n; i++) begin
      if (pos < 0 && held_vals[i] == v) pos = i;
    end
    r.found    = (pos >= 0);
    r.changed  = 1'b0;
    r.full_res = 1'b0;
    if (op == ist_pkg::OP_ADD && pos < 0) begin
      if (held_n < CAPACITY) begin
        held_vals[held_n] = v;
        held_n++;
        r.changed = 1'b1;
      end else begin
        r.full_res = 1'b1;
      end
    end else if (op == ist_pkg::OP_ERASE && pos >= 0) begin
      for (int i = pos + 1; i < held_n; i++) held_vals[i-1] = held_vals[i];
      held_n--;
      r.changed = 1'b1;
    end
    r.count = ist_pkg::CountW'(held_n);
    return r;
  endfunction

  // send one beat, optionally after an idle gap; predict once it is taken
  task automatic send_item(input logic [1:0] op, input logic signed [ist_pkg::ValueW-1:0] v);
    int unsigned gap;
    ist_pkg::ist_res_t res;
    if (idle_en && $urandom_range(99) < 7) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * CAPACITY) : $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    opcode_i <= op;
    value_i  <= v;
    do @(posedge clk_i); while (busy_o);
    res = apply_set_op(op, v);
    if (res.full_res) refused_adds++;
    if (held_n > peak_count) peak_count = held_n;
    predicted_res_q.push_back(res);
    items_sent++;
  endtask

  // pick a value that is currently held
  function automatic logic signed [ist_pkg::ValueW-1:0] held_pick();
    return held_vals[$urandom_range(held_n - 1)];
  endfunction

  // extremes of the value range, every opcode, duplicates and absent erases
  task automatic test_directed_cases();
    send_item(ist_pkg::OP_QUERY, 0);
    send_item(ist_pkg::OP_ERASE, 0);
    send_item(ist_pkg::OP_ADD, ValMin);
    send_item(ist_pkg::OP_ADD, ValMax);
    send_item(ist_pkg::OP_ADD, 0);
    send_item(ist_pkg::OP_ADD, -1);
    send_item(ist_pkg::OP_ADD, 1);
    send_item(ist_pkg::OP_ADD, ValMin);
    send_item(ist_pkg::OP_QUERY, ValMax);
    send_item(ist_pkg::OP_QUERY, 32'sh7FFF_FFFE);
    send_item(OP_SPARE, ValMin);
    send_item(OP_SPARE, 5);
    send_item(ist_pkg::OP_ERASE, 0);
    send_item(ist_pkg::OP_QUERY, 0);
    send_item(ist_pkg::OP_ERASE, 0);
    send_item(ist_pkg::OP_ERASE, ValMin);
    send_item(ist_pkg::OP_ERASE, 1);
    send_item(ist_pkg::OP_ADD, 32'sh5555_5555);
    send_item(ist_pkg::OP_ADD, 32'shAAAA_AAAA);
    send_item(ist_pkg::OP_QUERY, 32'shAAAA_AAAA);
    send_item(ist_pkg::OP_ERASE, -1);
    send_item(ist_pkg::OP_ERASE, ValMax);
    send_item(ist_pkg::OP_ERASE, 32'sh5555_5555);
    send_item(ist_pkg::OP_ERASE, 32'shAAAA_AAAA);
    send_item(ist_pkg::OP_QUERY, -1);
  endtask

  // fill to capacity, refuse an add when full, then drain in random order
  task automatic test_fill_to_capacity();
    while (held_n < CAPACITY) send_item(ist_pkg::OP_ADD, $urandom);
    send_item(ist_pkg::OP_ADD, $urandom);
    send_item(ist_pkg::OP_ADD, held_pick());
    send_item(ist_pkg::OP_QUERY, held_vals[CAPACITY-1]);
    send_item(OP_SPARE, held_vals[0]);
    send_item(ist_pkg::OP_ERASE, held_vals[CAPACITY-1]);
    send_item(ist_pkg::OP_ADD, $urandom);
    send_item(ist_pkg::OP_ADD, $urandom);
    send_item(ist_pkg::OP_ERASE, held_vals[0]);
    send_item(ist_pkg::OP_ADD, ValMin);
    send_item(ist_pkg::OP_ADD, ValMax);
    while (held_n > 0) begin
      if ($urandom_range(9) == 0) send_item(ist_pkg::OP_QUERY, $urandom);
      else send_item(ist_pkg::OP_ERASE, held_pick());
    end
  endtask

  // random mix over a value pool a little larger than the set, bias changing per block
  task automatic test_random_mix();
    logic signed [ist_pkg::ValueW-1:0] pool [PoolSize];
    logic signed [ist_pkg::ValueW-1:0] v;
    logic [1:0] op;
    int unsigned add_pct;
    int unsigned r;
    for (int k = 0; k < PoolSize; k++) pool[k] = $urandom;
    add_pct = 50;
    for (int n = 0; n < 100; n++) begin
      if (n % 25 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 75;
          1: add_pct = 45;
          default: add_pct = 20;
        endcase
      end
      // one long stretch with no sender idling
      idle_en = !(n >= 35 && n < 75);
      r = $urandom_range(99);
      if (r < add_pct) begin
        op = ist_pkg::OP_ADD;
      end else begin
        r = $urandom_range(99);
        if (r < 60) op = ist_pkg::OP_ERASE;
        else if (r < 90) op = ist_pkg::OP_QUERY;
        else op = OP_SPARE;
      end
      if ($urandom_range(99) < 85) v = pool[$urandom_range(PoolSize - 1)];
      else v = $urandom;
      send_item(op, v);
    end
    idle_en = 1'b1;
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    ist_pkg::ist_res_t exp_res;
    if (rst_ni && done_o === 1'b1) begin
      if (predicted_res_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        fail_cnt++;
      end else begin
        exp_res = predicted_res_q.pop_front();
        results_seen++;
        if (found_o !== exp_res.found) begin
          $error("found: expected %0b, got %0b", exp_res.found, found_o);
          fail_cnt++;
        end
        if (changed_o !== exp_res.changed) begin
          $error("changed: expected %0b, got %0b", exp_res.changed, changed_o);
          fail_cnt++;
        end
        if (full_res_o !== exp_res.full_res) begin
          $error("full_res: expected %0b, got %0b", exp_res.full_res, full_res_o);
          fail_cnt++;
        end
        if (count_o !== exp_res.count) begin
          $error("count: expected %0d, got %0d", exp_res.count, count_o);
          fail_cnt++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_fill_to_capacity();
    test_random_mix();
    start_i <= 1'b0;
    while (predicted_res_q.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    $display("covered %0d beats and %0d results: directed extremes, fill to %0d and drain,",
             items_sent, results_seen, peak_count);
    $display("random add/erase/query mix with %0d adds refused on a full set", refused_adds);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 1_500_000);
    $display("timeout: %0d predictions still waiting", predicted_res_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
